### src/csjb_pkg.sv
// Package: shared constants, register indexes, controller types and command/status structs.
package csjb_pkg;

  localparam int unsigned POS_BITS_DEF = 40;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned BIN_W = 32;
  localparam int unsigned OUT_POS_W = 40;
  localparam int unsigned BSIZE_W = 21;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_MAPQ     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ANCHOR   = 3'd4;

  localparam logic [7:0] CH_M  = 8'h4D;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_X  = 8'h58;
  localparam logic [7:0] CH_D  = 8'h44;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVA_GO,
    ST_DIVA_RUN,
    ST_DIVB_GO,
    ST_DIVB_RUN,
    ST_CHECK,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic step;
    logic div_start;
    logic div_sel;
    logic div_store;
    logic check;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic check_go;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

### src/csjb_div.sv
// Restoring divider: one quotient bit per cycle, position dividend by bin width.
module csjb_div import csjb_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [POS_BITS-1:0] dividend_i,
  input  logic [BSIZE_W-1:0]  divisor_i,
  output logic                busy_o,
  output logic                done_o,
  output logic [POS_BITS-1:0] quot_o,
  output logic [BSIZE_W-1:0]  rem_o
);

  localparam int unsigned CNT_W = $clog2(POS_BITS);

  logic [POS_BITS-1:0] sh_q, sh_d;
  logic [BSIZE_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [BSIZE_W:0]    trial;
  logic                qbit;

  always_comb begin
    trial = {rem_q, sh_q[POS_BITS-1]};
    qbit  = (trial >= {1'b0, divisor_i});
    sh_d = sh_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      sh_d = dividend_i;
      rem_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      sh_d = {sh_q[POS_BITS-2:0], qbit};
      rem_d = qbit ? BSIZE_W'(trial - {1'b0, divisor_i}) : trial[BSIZE_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(POS_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = sh_q;
  assign rem_o = rem_q;

endmodule

### src/csjb_ctrl.sv
// Controller: sequences character steps, the two bin divisions, the pair check and the emit.
module csjb_ctrl import csjb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && sts_i.check_go) state_d = ST_DIVA_GO;
      end
      ST_DIVA_GO: state_d = ST_DIVA_RUN;
      ST_DIVA_RUN: begin
        if (sts_i.div_done) state_d = ST_DIVB_GO;
      end
      ST_DIVB_GO: state_d = ST_DIVB_RUN;
      ST_DIVB_RUN: begin
        if (sts_i.div_done) state_d = ST_CHECK;
      end
      ST_CHECK: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.step = s_axis_tvalid;
      end
      ST_DIVA_GO: cmd_o.div_start = 1'b1;
      ST_DIVA_RUN: cmd_o.div_store = sts_i.div_done;
      ST_DIVB_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel = 1'b1;
      end
      ST_DIVB_RUN: begin
        cmd_o.div_sel = 1'b1;
        cmd_o.div_store = sts_i.div_done;
      end
      ST_CHECK: cmd_o.check = 1'b1;
      ST_EMIT: cmd_o.emit = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### src/csjb_dp.sv
// Datapath: configuration, CIGAR parse state, pair snapshot, bin math and output register.
module csjb_dp import csjb_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [47:0]           s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [143:0]          m_axis_tdata,
  input  ctrl_cmd_t             cmd_i,
  output ctrl_sts_t             sts_o
);

  localparam int unsigned PB = POS_BITS;

  logic [31:0]        region_start_q, region_end_q;
  logic [BSIZE_W-1:0] bin_size_q, min_anchor_q;
  logic [7:0]         min_mapq_q;

  logic [31:0]   run_q, run_d;
  logic [PB-1:0] pos_q, pos_d, of_q, of_d, ol_q, ol_d, pf_q, pf_d, pl_q, pl_d;
  logic          ov_q, ov_d, pv_q, pv_d, pass_q, pass_d;

  logic [PB-1:0] sa_first_q, sa_last_q, sb_first_q, sb_last_q;
  logic [BIN_W-1:0] qa_q, qb_q;
  logic [PB-1:0] bsa_q, bsb_q;
  logic          ok_q;

  logic          out_valid_q;
  logic [143:0]  out_data_q;

  logic [7:0]  ch;
  logic [31:0] run0, len32;
  logic [PB-1:0] pos0, len, of1, ol1;
  logic ov0, ov1, pv0, pass0, is_digit, is_blk, is_n, closing;

  logic [PB-1:0] org, p_sel, p_clamp, dvd;
  logic [BSIZE_W-1:0] wdt;
  logic div_busy, div_done;
  logic [PB-1:0] div_q;
  logic [BSIZE_W-1:0] div_r;

  logic win_ok, anc_ok, ok_d;
  logic [BIN_W-1:0] bin_lo, bin_hi;
  logic [63:0] de_ext, as_ext;

  function automatic logic in_win(input logic [PB-1:0] p, input logic [PB-1:0] o,
                                  input logic [31:0] re);
    in_win = (p >= o) && (p <= PB'(re));
  endfunction

  function automatic logic [PB+1:0] ovl(input logic [PB-1:0] s, input logic [PB-1:0] e,
                                        input logic [PB-1:0] bs, input logic [BSIZE_W-1:0] w);
    logic [PB:0] be, hi, lo;
    be = {1'b0, bs} + (PB+1)'(w - BSIZE_W'(1));
    if (PB == 64 && be[PB]) be = {1'b0, {PB{1'b1}}};
    hi = ({1'b0, e} < be) ? {1'b0, e} : be;
    lo = (s > bs) ? {1'b0, s} : {1'b0, bs};
    ovl = (hi >= lo) ? ((PB+2)'(hi) - (PB+2)'(lo) + (PB+2)'(1)) : '0;
  endfunction

  assign org = (region_start_q == 32'd0) ? PB'(1) : PB'(region_start_q);
  assign wdt = (bin_size_q == '0) ? BSIZE_W'(1) : bin_size_q;

  always_comb begin
    ch = s_axis_tdata[7:0];
    pos0 = s_axis_tuser ? (PB'(s_axis_tdata[39:8]) + PB'(1)) : pos_q;
    run0 = s_axis_tuser ? 32'd0 : run_q;
    ov0 = s_axis_tuser ? 1'b0 : ov_q;
    pv0 = s_axis_tuser ? 1'b0 : pv_q;
    pass0 = s_axis_tuser ? ((min_mapq_q == 8'd0) || (s_axis_tdata[47:40] >= min_mapq_q))
                         : pass_q;
    is_digit = (ch >= CH_0) && (ch <= CH_9);
    is_blk = !is_digit && (run0 != 32'd0) && ((ch == CH_M) || (ch == CH_EQ) || (ch == CH_X));
    is_n = !is_digit && (run0 != 32'd0) && (ch == CH_N);
    len32 = run0;
    len = PB'(len32);
    run_d = 32'd0;
    if (is_digit) run_d = (run0 << 3) + (run0 << 1) + 32'(ch - CH_0);
    pos_d = pos0;
    of1 = of_q;
    ol1 = ol_q;
    ov1 = ov0;
    if (is_blk) begin
      if (!ov0) of1 = pos0;
      ov1 = 1'b1;
      ol1 = pos0 + len - PB'(1);
    end
    if (!is_digit && (run0 != 32'd0) && (is_blk || is_n || (ch == CH_D))) pos_d = pos0 + len;
    closing = (is_n && ov0) || (!is_n && s_axis_tlast && ov1);
    of_d = of1;
    ol_d = ol1;
    ov_d = closing ? 1'b0 : ov1;
    pv_d = closing ? 1'b1 : pv0;
    pf_d = closing ? of1 : pf_q;
    pl_d = closing ? ol1 : pl_q;
    pass_d = pass0;
  end

  assign sts_o.check_go = closing && pv0 && pass0;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || m_axis_tready;

  assign p_sel = cmd_i.div_sel ? sb_first_q : sa_last_q;
  assign p_clamp = (p_sel < org) ? org : p_sel;
  assign dvd = p_clamp - org;

  csjb_div #(.POS_BITS(PB)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (wdt),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  always_comb begin
    win_ok = (region_end_q == 32'd0) ||
             (in_win(sa_last_q, org, region_end_q) && in_win(sb_first_q, org, region_end_q));
    anc_ok = (min_anchor_q <= BSIZE_W'(1)) ||
             ((ovl(sa_first_q, sa_last_q, bsa_q, wdt) >= (PB+2)'(min_anchor_q)) &&
              (ovl(sb_first_q, sb_last_q, bsb_q, wdt) >= (PB+2)'(min_anchor_q)));
    ok_d = win_ok && anc_ok;
    bin_lo = (qa_q < qb_q) ? qa_q : qb_q;
    bin_hi = (qa_q < qb_q) ? qb_q : qa_q;
    de_ext = 64'(sa_last_q);
    as_ext = 64'(sb_first_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= 32'd1;
      region_end_q <= 32'd0;
      bin_size_q <= BSIZE_W'(250);
      min_mapq_q <= 8'd0;
      min_anchor_q <= BSIZE_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_REGION_START: region_start_q <= cfg_data_i;
        REG_REGION_END:   region_end_q <= cfg_data_i;
        REG_BIN_SIZE:     bin_size_q <= cfg_data_i[BSIZE_W-1:0];
        REG_MIN_MAPQ:     min_mapq_q <= cfg_data_i[7:0];
        REG_MIN_ANCHOR:   min_anchor_q <= cfg_data_i[BSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      pos_q <= '0;
      of_q <= '0;
      ol_q <= '0;
      pf_q <= '0;
      pl_q <= '0;
      ov_q <= 1'b0;
      pv_q <= 1'b0;
      pass_q <= 1'b0;
    end else if (cmd_i.step) begin
      run_q <= run_d;
      pos_q <= pos_d;
      of_q <= of_d;
      ol_q <= ol_d;
      pf_q <= pf_d;
      pl_q <= pl_d;
      ov_q <= ov_d;
      pv_q <= pv_d;
      pass_q <= pass_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      sa_first_q <= pf_q;
      sa_last_q <= pl_q;
      sb_first_q <= of1;
      sb_last_q <= ol1;
    end
    if (cmd_i.div_store) begin
      if (cmd_i.div_sel) begin
        qb_q <= div_q[BIN_W-1:0];
        bsb_q <= p_clamp - PB'(div_r);
      end else begin
        qa_q <= div_q[BIN_W-1:0];
        bsa_q <= p_clamp - PB'(div_r);
      end
    end
    if (cmd_i.check) ok_q <= ok_d;
    if (cmd_i.emit && ok_q) begin
      out_data_q <= {as_ext[OUT_POS_W-1:0], de_ext[OUT_POS_W-1:0], bin_hi, bin_lo};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit && ok_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy) else $error("divider restarted while busy");
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && ok_q) |=> m_axis_tvalid) else $error("passing pair not presented");
  a_no_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !cmd_i.step) else $error("character taken during division");

endmodule

### src/cigar_splice_junction_binner_top.sv
// Top level: CIGAR splice junction binner, controller plus datapath.
// A character word is taken when the block is idle. A word that closes a
// block with an earlier block and a passing mapq holds the input while the
// one-bit-per-cycle bin divider runs once for the donor end and once for the
// acceptor start, then through a check and an emit state;
// the emit waits while the previous junction word is still unread.
module cigar_splice_junction_binner_top import csjb_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [47:0]           s_axis_tdata,  // cigar_char, align_start, map_quality
  input  logic                  s_axis_tuser,  // record_start
  input  logic                  s_axis_tlast,  // record_end
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [143:0]          m_axis_tdata   // bin_low, bin_high, donor_end, acceptor_start
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  csjb_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  csjb_dp #(.POS_BITS(POS_BITS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

### tb/sv/cigar_splice_junction_binner_top_test.sv
// Testbench: CIGAR splice junction binner, streamed records checked against a predictor.
`timescale 1ns / 1ps

module cigar_splice_junction_binner_top_test;
  import csjb_pkg::*;

  typedef struct packed {
    logic [39:0] acceptor_start;
    logic [39:0] donor_end;
    logic [31:0] bin_high;
    logic [31:0] bin_low;
  } junction_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [47:0]           s_axis_tdata = '0;  // cigar_char, align_start, map_quality
  logic                  s_axis_tuser = 1'b0;  // record_start
  logic                  s_axis_tlast = 1'b0;  // record_end
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [143:0]          m_axis_tdata;  // bin_low, bin_high, donor_end, acceptor_start

  cigar_splice_junction_binner_top dut (.*);

  // predictor copy of the registers and the parse state
  logic [31:0] reg_rstart, reg_rend;
  logic [20:0] reg_bsize, reg_anchor;
  logic [7:0]  reg_mapq;
  logic [31:0] run_len;
  logic [39:0] pos, open_lo, open_hi, prev_lo, prev_hi;
  logic        open_ok, prev_ok, rec_pass;

  junction_t   junction_q[$];
  logic [7:0]  cigar_q[$];
  int          errors = 0;
  int          words_sent = 0;
  int          junctions_seen = 0;
  int          long_hold = 0;
  bit          burst = 1'b0;
  int          idle_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] bin_of(logic [63:0] p, output logic [63:0] bstart);
    logic [63:0] r1, w, d;
    r1 = (reg_rstart == 0) ? 64'd1 : 64'(reg_rstart);
    w = (reg_bsize == 0) ? 64'd1 : 64'(reg_bsize);
    if (p < r1) p = r1;
    d = p - r1;
    bstart = p - d % w;
    return d / w;
  endfunction

  function automatic logic [63:0] overlap(logic [63:0] s, logic [63:0] e, logic [63:0] bs);
    logic [63:0] be, hi, lo;
    be = bs + ((reg_bsize == 0) ? 64'd0 : 64'(reg_bsize) - 1);
    hi = (e < be) ? e : be;
    lo = (s > bs) ? s : bs;
    return (hi >= lo) ? hi - lo + 1 : 64'd0;
  endfunction

  function automatic bit in_window(logic [63:0] p);
    logic [63:0] r1;
    r1 = (reg_rstart == 0) ? 64'd1 : 64'(reg_rstart);
    return p >= r1 && p <= 64'(reg_rend);
  endfunction

  function automatic bit close_block(output junction_t j);
    bit ok, got;
    logic [63:0] bsa, bsb, bi, bj;
    got = 1'b0;
    j = '0;
    if (!open_ok) return 1'b0;
    if (prev_ok && rec_pass) begin
      ok = 1'b1;
      if (reg_rend != 0 && (!in_window(64'(prev_hi)) || !in_window(64'(open_lo)))) ok = 1'b0;
      bi = bin_of(64'(prev_hi), bsa);
      bj = bin_of(64'(open_lo), bsb);
      if (ok && reg_anchor > 1) begin
        if (overlap(64'(prev_lo), 64'(prev_hi), bsa) < 64'(reg_anchor) ||
            overlap(64'(open_lo), 64'(open_hi), bsb) < 64'(reg_anchor)) ok = 1'b0;
      end
      if (ok) begin
        j.bin_low = (bi[31:0] < bj[31:0]) ? bi[31:0] : bj[31:0];
        j.bin_high = (bi[31:0] < bj[31:0]) ? bj[31:0] : bi[31:0];
        j.donor_end = prev_hi;
        j.acceptor_start = open_lo;
        got = 1'b1;
      end
    end
    prev_lo = open_lo;
    prev_hi = open_hi;
    prev_ok = 1'b1;
    open_ok = 1'b0;
    return got;
  endfunction

  function automatic void predict_junction(logic [47:0] d, logic first, logic last);
    logic [7:0] c;
    bit got;
    junction_t j;
    c = d[7:0];
    got = 1'b0;
    if (first) begin
      pos = 40'(d[39:8]) + 40'd1;
      run_len = '0;
      open_ok = 1'b0;
      prev_ok = 1'b0;
      rec_pass = (reg_mapq == 0) || (d[47:40] >= reg_mapq);
    end
    if (c >= CH_0 && c <= CH_9) begin
      run_len = run_len * 10 + 32'(c - CH_0);
    end else if (run_len != 0) begin
      if (c == CH_M || c == CH_EQ || c == CH_X) begin
        if (!open_ok) begin
          open_lo = pos;
          open_ok = 1'b1;
        end
        open_hi = pos + 40'(run_len) - 40'd1;
        pos = pos + 40'(run_len);
      end else if (c == CH_D) begin
        pos = pos + 40'(run_len);
      end else if (c == CH_N) begin
        got = close_block(j);
        pos = pos + 40'(run_len);
      end
      run_len = '0;
    end
    if (last && !got) got = close_block(j);
    if (got) junction_q = {junction_q, j};
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_REGION_START: reg_rstart = val;
      REG_REGION_END:   reg_rend = val;
      REG_BIN_SIZE:     reg_bsize = val[20:0];
      REG_MIN_MAPQ:     reg_mapq = val[7:0];
      REG_MIN_ANCHOR:   reg_anchor = val[20:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (junction_q.size() == 0);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic setup(logic [31:0] rs, logic [31:0] re, logic [31:0] bs,
                       logic [31:0] mq, logic [31:0] an);
    drain();
    write_reg(REG_REGION_START, rs);
    write_reg(REG_REGION_END, re);
    write_reg(REG_BIN_SIZE, bs);
    write_reg(REG_MIN_MAPQ, mq);
    write_reg(REG_MIN_ANCHOR, an);
  endtask

  task automatic send_word(logic [7:0] c, logic [31:0] astart, logic [7:0] mq,
                           logic first, logic last);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {mq, astart, c};
    s_axis_tuser <= first;
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_junction({mq, astart, c}, first, last);
    words_sent++;
  endtask

  task automatic add_run(longint unsigned len, logic [7:0] op);
    string s;
    s = $sformatf("%0d", len);
    foreach (s[i]) cigar_q = {cigar_q, s[i]};
    cigar_q = {cigar_q, op};
  endtask

  task automatic send_cigar(logic [31:0] astart, logic [7:0] mq, bit first, bit last);
    foreach (cigar_q[i])
      send_word(cigar_q[i], astart, mq, first && i == 0, last && i == cigar_q.size() - 1);
    cigar_q.delete();
  endtask

  task automatic send_text(string s, logic [31:0] astart, logic [7:0] mq, bit first, bit last);
    foreach (s[i]) cigar_q = {cigar_q, s[i]};
    send_cigar(astart, mq, first, last);
  endtask

  function automatic logic [7:0] pick_op();
    int r;
    string ops;
    ops = "ISHP";
    r = $urandom_range(0, 99);
    if (r < 40) return CH_M;
    if (r < 62) return CH_N;
    if (r < 72) return CH_D;
    if (r < 78) return CH_EQ;
    if (r < 84) return CH_X;
    if (r < 94) return ops[$urandom_range(0, 3)];
    return 8'($urandom_range(65, 122));
  endfunction

  function automatic longint unsigned pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 0;
    if (r < 7) return longint'($urandom) * 1000 + $urandom_range(0, 999);
    if (r < 15) return $urandom_range(1, 5000);
    return $urandom_range(1, 300);
  endfunction

  // one record or a burst of noise; returns the word count
  task automatic send_record(output int n);
    logic [31:0] astart;
    int nops, r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      nops = $urandom_range(1, 5);
      repeat (nops)
        send_word(8'($urandom), $urandom, 8'($urandom), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      n = nops;
      return;
    end
    astart = ($urandom_range(0, 4) == 0) ? $urandom : reg_rstart - 200 + $urandom_range(0, 3000);
    if ($urandom_range(0, 19) == 0) astart = 32'hFFFF_FFFF;
    nops = $urandom_range(1, 7);
    repeat (nops) add_run(pick_len(), pick_op());
    if ($urandom_range(0, 9) == 0) cigar_q = {cigar_q, 8'($urandom_range(CH_0, CH_9))};
    n = cigar_q.size();
    send_cigar(astart, 8'($urandom), $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
  endtask

  task automatic send_records(int count);
    int n;
    while (count > 0) begin
      if ($urandom_range(0, 15) == 0) burst = ~burst;
      send_record(n);
      count -= n;
    end
  endtask

  task automatic test_directed();
    send_text("2M", 32'd7, 8'd9, 1'b0, 1'b1);
    send_text("4M2N3M", 32'd0, 8'hFF, 1'b1, 1'b1);
    send_text("0M2=1D3N1X1N", 32'd5, 8'd0, 1'b1, 1'b1);
    send_text("1S2M", 32'hFFFF_FFFF, 8'd1, 1'b1, 1'b0);
  endtask

  task automatic test_settings();
    setup(32'd1, 32'd0, 32'd250, 32'd0, 32'd1);
    send_records(250);
    setup(32'd1000, 32'd6000, 32'd100, 32'd30, 32'd20);
    send_records(250);
    setup(32'd0, 32'd0, 32'd0, 32'd0, 32'd1);
    send_records(250);
    setup(32'hFFFF_F000, 32'hFFFF_FFFF, 32'd1048576, 32'd255, 32'd1048576);
    send_records(200);
    setup(32'd500, 32'hFFFF_FFFF, 32'd7, 32'd0, 32'd3);
    send_records(250);
    repeat (2) begin
      setup($urandom_range(1, 5000), ($urandom_range(0, 1) == 0) ? 0 : $urandom,
            $urandom_range(1, 1 << 20), $urandom_range(0, 255), $urandom_range(1, 400));
      send_records(120);
    end
  endtask

  task automatic test_backpressure();
    setup(32'd1, 32'd0, 32'd50, 32'd0, 32'd1);
    long_hold = 800;
    burst = 1'b1;
    repeat (20) send_text("3M5N4M6N2M", $urandom_range(0, 2000), 8'($urandom), 1'b1, 1'b1);
    burst = 1'b0;
  endtask

  initial begin
    reg_rstart = 1; reg_rend = 0; reg_bsize = 250; reg_mapq = 0; reg_anchor = 1;
    run_len = 0; pos = 0; open_lo = 0; open_hi = 0; prev_lo = 0; prev_hi = 0;
    open_ok = 0; prev_ok = 0; rec_pass = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_settings();
    test_backpressure();
    drain();
    $display("%0d character words sent, %0d junction words checked over 8 register settings",
             words_sent, junctions_seen);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin : junction_checker
    int stall;
    junction_t got, want;
    forever begin
      if (long_hold > 0) begin
        stall = long_hold;
        long_hold = 0;
      end else begin
        stall = $urandom_range(0, 9);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got = m_axis_tdata;
      junctions_seen++;
      if (junction_q.size() == 0) begin
        $display("%0t junction word exp none got %h", $time, got);
        errors++;
      end else begin
        want = junction_q.pop_front();
        if (got.bin_low !== want.bin_low) begin
          $display("%0t bin_low exp %h got %h", $time, want.bin_low, got.bin_low);
          errors++;
        end
        if (got.bin_high !== want.bin_high) begin
          $display("%0t bin_high exp %h got %h", $time, want.bin_high, got.bin_high);
          errors++;
        end
        if (got.donor_end !== want.donor_end) begin
          $display("%0t donor_end exp %h got %h", $time, want.donor_end, got.donor_end);
          errors++;
        end
        if (got.acceptor_start !== want.acceptor_start) begin
          $display("%0t acceptor_start exp %h got %h", $time, want.acceptor_start,
                   got.acceptor_start);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("%0t watchdog expired, %0d junctions pending", $time, junction_q.size());
      $display("simulation failed");
      $finish;
    end
  end

endmodule
